>>> hdl/gbfc_pkg.sv
// shared types, codes and helpers for the glyph bitmap format converter
package gbfc_pkg;

  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int ROW_W       = 10;
  localparam int ROWS_W      = 11;

  localparam logic [2:0] MODE_MONO = 3'd0;
  localparam logic [2:0] MODE_GRAY = 3'd1;
  localparam logic [2:0] MODE_LCDH = 3'd2;
  localparam logic [2:0] MODE_LCDV = 3'd3;
  localparam logic [2:0] MODE_BGRA = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FMT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BGR_ORDER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS   = 2'd3;

  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_XRGB = 3'd4;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  localparam logic [ROWS_W-1:0] ROW_LIMIT = 11'd1024;

  typedef struct packed {
    logic [2:0]       fmt_mode;
    logic             bgr_order;
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_rows;
  } cfg_t;

  // first stage result, waiting for the line store data and the output register
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        row_end;
    logic        glyph_end;
    logic        vert;
    logic [7:0]  src_byte;
  } s1_t;

  function automatic logic [31:0] pack_xrgb(input logic bgr, input logic [7:0] s0,
                                            input logic [7:0] s1, input logic [7:0] s2);
    logic [7:0] red;
    logic [7:0] blue;
    red  = bgr ? s2 : s0;
    blue = bgr ? s0 : s2;
    return {8'h00, red, s1, blue};
  endfunction

endpackage

>>> hdl/gbfc_in_if.sv
// source byte channel
interface gbfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

>>> hdl/gbfc_out_if.sv
// converted result channel
interface gbfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  out_bytes;
  logic        row_end;
  logic        glyph_end;

  modport source (output valid, output out_word, output out_bytes, output row_end,
                  output glyph_end, input ready);
  modport sink   (input valid, input out_word, input out_bytes, input row_end,
                  input glyph_end, output ready);
endinterface

>>> hdl/gbfc_ram.sv
// generic single write port ram with registered read
module gbfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/gbfc_cfg.sv
// configuration registers and bitmap restart pulse
module gbfc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [gbfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbfc_pkg::CFG_W-1:0]     cfg_wdata,
  output gbfc_pkg::cfg_t                 cfg,
  output logic                           restart
);

  gbfc_pkg::cfg_t cfg_r;
  gbfc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        gbfc_pkg::REG_FMT_MODE:   cfg_nxt.fmt_mode   = cfg_wdata[2:0];
        gbfc_pkg::REG_BGR_ORDER:  cfg_nxt.bgr_order  = cfg_wdata[0];
        gbfc_pkg::REG_SRC_WIDTH:  cfg_nxt.src_width  = cfg_wdata;
        gbfc_pkg::REG_SRC_ROWS:   cfg_nxt.src_rows   = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt_mode   <= gbfc_pkg::MODE_GRAY;
      cfg_r.bgr_order  <= 1'b0;
      cfg_r.src_width  <= gbfc_pkg::CFG_W'(1);
      cfg_r.src_rows   <= gbfc_pkg::CFG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // every listed register write starts a new bitmap
  assign restart = cfg_wr_en;
  assign cfg     = cfg_r;

endmodule

>>> hdl/gbfc_ctrl.sv
// raster counters, subpixel holding, line stores and first stage register
module gbfc_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gbfc_pkg::cfg_t cfg,
  input  logic           restart,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           s1_take,
  output logic           s1_valid,
  output gbfc_pkg::s1_t  s1,
  output logic [7:0]     rd0,
  output logic [7:0]     rd1
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (EW > gbfc_pkg::CFG_W) ? EW : gbfc_pkg::CFG_W;
  localparam int FW   = EW + 2;
  localparam int RW   = EW + 3;
  localparam int VW   = gbfc_pkg::ROWS_W + 1;

  logic [CW-1:0]                col_r, col_nxt;
  logic [gbfc_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [15:0]                  held_r, held_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  gbfc_pkg::s1_t                s1_r, s1_nxt;

  logic                         in_accept;
  logic [EW-1:0]                eff_w;
  logic [gbfc_pkg::ROWS_W-1:0]  eff_rows;
  logic [EW-1:0]                per_row;
  logic [EW:0]                  per_row_mono;
  logic                         last_col, last_row;
  logic [RW-1:0]                mono_rem;
  logic [3:0]                   mono_valid;
  logic [7:0]                   mono_mask, mono_rev;
  logic                         h_full, h_last, v_full, v_last;
  logic                         emit;
  logic                         wr0, wr1, rd_en;

  assign in_ready  = !s1_valid_r || s1_take;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (cfg.src_width == '0) begin
      eff_w = EW'(1);
    end else if (CMPW'(cfg.src_width) > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg.src_width);
    end
    if (cfg.src_rows == '0) begin
      eff_rows = gbfc_pkg::ROWS_W'(1);
    end else if (cfg.src_rows > gbfc_pkg::ROW_LIMIT) begin
      eff_rows = gbfc_pkg::ROW_LIMIT;
    end else begin
      eff_rows = cfg.src_rows;
    end
  end

  assign per_row_mono = ((EW + 1)'(eff_w) + (EW + 1)'(7)) >> 3;
  assign per_row  = (cfg.fmt_mode == gbfc_pkg::MODE_MONO) ? EW'(per_row_mono) : eff_w;
  assign last_col = ((EW + 1)'(col_r) + (EW + 1)'(1)) >= (EW + 1)'(per_row);
  assign last_row = (gbfc_pkg::ROWS_W'(row_r) + gbfc_pkg::ROWS_W'(1)) >= eff_rows;

  // mono: pixels still left in this byte, capped at eight
  assign mono_rem   = RW'(eff_w) - RW'({col_r, 3'b000});
  assign mono_valid = (mono_rem >= RW'(8)) ? 4'd8 : mono_rem[3:0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mono_mask[i] = (4'(i) < mono_valid);
      mono_rev[i]  = in_byte[7 - i];
    end
  end

  // phase tracks column mod 3 (horizontal) or row mod 3 (vertical),
  // so complete groups are found without dividing the width or row count
  assign h_full = (FW'(col_r) + FW'(3) - FW'(phase_r)) <= FW'(eff_w);
  assign h_last = (FW'(col_r) + FW'(4)) > FW'(eff_w);
  assign v_full = (VW'(row_r) + VW'(3) - VW'(phase_r)) <= VW'(eff_rows);
  assign v_last = (VW'(row_r) + VW'(4)) > VW'(eff_rows);

  always_comb begin
    emit             = 1'b0;
    wr0              = 1'b0;
    wr1              = 1'b0;
    rd_en            = 1'b0;
    s1_nxt           = s1_r;
    s1_nxt.word      = {24'h000000, in_byte};
    s1_nxt.nbytes    = gbfc_pkg::BYTES_ONE;
    s1_nxt.row_end   = last_col;
    s1_nxt.glyph_end = last_col && last_row;
    s1_nxt.vert      = 1'b0;
    s1_nxt.src_byte  = in_byte;
    phase_nxt        = phase_r;
    held_nxt         = held_r;

    unique case (cfg.fmt_mode)
      gbfc_pkg::MODE_MONO: begin
        emit        = 1'b1;
        s1_nxt.word = {24'h000000, mono_rev & mono_mask};
      end
      gbfc_pkg::MODE_LCDH: begin
        if (h_full) begin
          unique case (phase_r)
            gbfc_pkg::PHASE_FIRST: begin
              held_nxt  = {8'h00, in_byte};
              phase_nxt = gbfc_pkg::PHASE_SECOND;
            end
            gbfc_pkg::PHASE_SECOND: begin
              held_nxt  = {in_byte, held_r[7:0]};
              phase_nxt = gbfc_pkg::PHASE_THIRD;
            end
            default: begin
              emit             = 1'b1;
              s1_nxt.word      = gbfc_pkg::pack_xrgb(cfg.bgr_order, held_r[7:0],
                                                     held_r[15:8], in_byte);
              s1_nxt.nbytes    = gbfc_pkg::BYTES_XRGB;
              s1_nxt.row_end   = h_last;
              s1_nxt.glyph_end = h_last && last_row;
              phase_nxt        = gbfc_pkg::PHASE_FIRST;
            end
          endcase
        end
      end
      gbfc_pkg::MODE_LCDV: begin
        if (v_full) begin
          unique case (phase_r)
            gbfc_pkg::PHASE_FIRST:  wr0 = 1'b1;
            gbfc_pkg::PHASE_SECOND: wr1 = 1'b1;
            default: begin
              emit             = 1'b1;
              rd_en            = 1'b1;
              s1_nxt.vert      = 1'b1;
              s1_nxt.nbytes    = gbfc_pkg::BYTES_XRGB;
              s1_nxt.glyph_end = last_col && v_last;
            end
          endcase
        end
      end
      default: emit = 1'b1;
    endcase

    if (last_col) begin
      col_nxt = '0;
      if (cfg.fmt_mode == gbfc_pkg::MODE_LCDH) begin
        phase_nxt = gbfc_pkg::PHASE_FIRST;
        held_nxt  = '0;
      end else if (cfg.fmt_mode == gbfc_pkg::MODE_LCDV) begin
        phase_nxt = (phase_r >= gbfc_pkg::PHASE_THIRD) ? gbfc_pkg::PHASE_FIRST
                                                       : phase_r + 2'd1;
      end
      if (last_row) begin
        row_nxt   = '0;
        phase_nxt = gbfc_pkg::PHASE_FIRST;
        held_nxt  = '0;
      end else begin
        row_nxt = gbfc_pkg::ROW_W'(row_r + 1'b1);
      end
    end else begin
      col_nxt = CW'(col_r + 1'b1);
      row_nxt = row_r;
    end

    if (in_accept) begin
      s1_valid_nxt = emit;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= gbfc_pkg::PHASE_FIRST;
      held_r  <= '0;
    end else if (in_accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  // line stores for the first and second row of a vertical group
  gbfc_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (in_accept && wr0),
    .waddr (col_r),
    .wdata (in_byte),
    .re    (in_accept && rd_en),
    .raddr (col_r),
    .rdata (rd0)
  );

  gbfc_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (in_accept && wr1),
    .waddr (col_r),
    .wdata (in_byte),
    .re    (in_accept && rd_en),
    .raddr (col_r),
    .rdata (rd1)
  );

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  a_glyph_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.glyph_end |-> s1_r.row_end)
    else $error("glyph end without row end");

  a_reset_clears_counters: assert property (@(posedge clk)
    !rst_n |=> (col_r == '0 && row_r == '0 && phase_r == gbfc_pkg::PHASE_FIRST))
    else $error("counters not cleared by reset");

  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (EW + 1)'(col_r) < (EW + 1)'(per_row))
    else $error("column count past the end of the row");

endmodule

>>> hdl/gbfc_out.sv
// second stage: vertical packing from the line stores and output register
module gbfc_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          bgr_order,
  input  logic          s1_valid,
  input  gbfc_pkg::s1_t s1,
  input  logic [7:0]    rd0,
  input  logic [7:0]    rd1,
  output logic          s1_take,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_word,
  output logic [2:0]    out_bytes,
  output logic          row_end,
  output logic          glyph_end
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] word_r, word_nxt;
  logic [2:0]  bytes_r;
  logic        row_end_r, glyph_end_r;
  logic        load;

  assign s1_take = !out_valid_r || out_ready;
  assign load    = s1_valid && s1_take;

  assign word_nxt = s1.vert ? gbfc_pkg::pack_xrgb(bgr_order, rd0, rd1, s1.src_byte)
                            : s1.word;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r      <= word_nxt;
      bytes_r     <= s1.nbytes;
      row_end_r   <= s1.row_end;
      glyph_end_r <= s1.glyph_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = word_r;
  assign out_bytes = bytes_r;
  assign row_end   = row_end_r;
  assign glyph_end = glyph_end_r;

endmodule

>>> hdl/glyph_bitmap_format_converter_core.sv
// top level of the glyph bitmap format converter
//
// in_ch carries one used source byte per beat in raster order, no row padding.
// out_ch carries one converted beat: a byte in out_word[7:0] (out_bytes 1) or
// an xrgb word (out_bytes 4), with row_end and glyph_end on the last beat of a
// destination row and of the bitmap. lcd groups that are not complete are
// consumed without a beat.
// cfg_wr_en/cfg_index/cfg_wdata write the mode, bgr_order, src_width and
// src_rows; any write restarts the bitmap. write only while the block is idle.
// a result beat passes the first stage register and then the output register to out_ch.
// throughput: one byte per cycle unless out_ch stalls; each byte is handled in a
// single pass and needs at most one access of each line store in lcd vertical mode.
// reset: registers return to gray mode, width 1, rows 1, counters zero; the
// line stores are not cleared, an entry is only read after it was written.
// when out_ch stalls, bytes are still taken until one makes a beat, which waits
// in the first stage, and then in_ch.ready drops until the output register is freed.
module glyph_bitmap_format_converter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [gbfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbfc_pkg::CFG_W-1:0]     cfg_wdata,
  gbfc_in_if.sink                        in_ch,
  gbfc_out_if.source                     out_ch
);

  gbfc_pkg::cfg_t cfg;
  gbfc_pkg::s1_t  s1;
  logic           restart;
  logic           s1_valid;
  logic           s1_take;
  logic [7:0]     rd0, rd1;

  gbfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .restart   (restart)
  );

  gbfc_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .restart  (restart),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.src_byte),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1       (s1),
    .rd0      (rd0),
    .rd1      (rd1)
  );

  gbfc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .bgr_order (cfg.bgr_order),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rd0       (rd0),
    .rd1       (rd1),
    .s1_take   (s1_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.out_word),
    .out_bytes (out_ch.out_bytes),
    .row_end   (out_ch.row_end),
    .glyph_end (out_ch.glyph_end)
  );

endmodule
